FILE: hdl/sensor_scan_collector_defines.svh
// ----------------------------------------------------------------------------
// Sensor scan collector assertion macros
// Concurrent check wrappers, active in simulation, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef SENSOR_SCAN_COLLECTOR_DEFINES_SVH
`define SENSOR_SCAN_COLLECTOR_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define SSC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("sensor_scan_collector check failed");
// next-cycle implication, checked out of reset
`define SSC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sensor_scan_collector sequence check failed");
`else
`define SSC_ASSERT(lbl, prop)
`define SSC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: hdl/ssc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared widths, opcodes and stage types of the sensor scan collector.
// ----------------------------------------------------------------------------
package ssc_pkg;

    localparam int OPCODE_W   = 2;
    localparam int DATA_W     = 8;
    localparam int BANK_IDX_W = 5;
    localparam int IDLE_W     = 8;

    // item opcodes
    localparam logic [OPCODE_W-1:0] OP_BYTE = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_TICK = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_READ = 2'd2;

    localparam logic [IDLE_W-1:0] IDLE_MAX      = '1;
    localparam logic [IDLE_W-1:0] TIMEOUT_RESET = 8'd10;

    // control carried with an item from the front end into the memory stage
    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic                wrap;
        logic                timed_out;
        logic                in_range;
    } t_s1_ctl;

    // one result item
    typedef struct packed {
        logic              request_dump;
        logic              scan_done;
        logic              scan_changed;
        logic              timed_out;
        logic [DATA_W-1:0] bank_bits;
    } t_result;

endpackage

FILE: hdl/ssc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_in_if
// Input item channel: valid/ready with opcode, dump byte and bank index.
// ----------------------------------------------------------------------------
interface ssc_in_if;
    logic                           valid;
    logic                           ready;
    logic [ssc_pkg::OPCODE_W-1:0]   opcode;
    logic [ssc_pkg::DATA_W-1:0]     data_byte;
    logic [ssc_pkg::BANK_IDX_W-1:0] bank_index;

    modport source (output valid, output opcode, output data_byte, output bank_index,
                    input ready);
    modport sink   (input valid, input opcode, input data_byte, input bank_index,
                    output ready);
endinterface

FILE: hdl/ssc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_out_if
// Result item channel: valid/ready with scan status flags and bank contents.
// ----------------------------------------------------------------------------
interface ssc_out_if;
    logic                       valid;
    logic                       ready;
    logic                       request_dump;
    logic                       scan_done;
    logic                       scan_changed;
    logic                       timed_out;
    logic [ssc_pkg::DATA_W-1:0] bank_bits;

    modport source (output valid, output request_dump, output scan_done,
                    output scan_changed, output timed_out, output bank_bits,
                    input ready);
    modport sink   (input valid, input request_dump, input scan_done,
                    input scan_changed, input timed_out, input bank_bits,
                    output ready);
endinterface

FILE: hdl/ssc_bank_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_bank_mem
// Bank store: one write and one registered read port, per-entry valid bits
// so that unwritten banks read as zero, and write-to-read forwarding.
// ----------------------------------------------------------------------------
module ssc_bank_mem #(
    parameter int DEPTH = 10,
    parameter int AW    = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_rd_en,
    input  logic [AW-1:0]              i_rd_addr,
    input  logic                       i_wr_en,
    input  logic [AW-1:0]              i_wr_addr,
    input  logic [ssc_pkg::DATA_W-1:0] i_wr_data,
    output logic [ssc_pkg::DATA_W-1:0] o_rd_data
);

    logic [ssc_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]           r_valid;
    logic [ssc_pkg::DATA_W-1:0] r_rd_data;
    logic                       r_rd_valid;
    logic                       r_fwd;
    logic [ssc_pkg::DATA_W-1:0] r_fwd_data;

    // storage write
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // valid bits, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    // registered read, catching a write to the same entry in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_rd_valid <= r_valid[i_rd_addr];
            r_fwd_data <= i_wr_data;
        end
    end

    assign o_rd_data = r_fwd      ? r_fwd_data :
                       r_rd_valid ? r_rd_data  : '0;

endmodule

FILE: hdl/ssc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_front
// Scan sequencer: byte position, decoder-pair flag and watchdog counter.
// Picks the bank address for each item and flags wrap and timeout.
// ----------------------------------------------------------------------------
module ssc_front #(
    parameter int BANK_COUNT = 10,
    parameter int AW         = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic [ssc_pkg::OPCODE_W-1:0]   i_opcode,
    input  logic [ssc_pkg::BANK_IDX_W-1:0] i_bank_index,
    input  logic [ssc_pkg::IDLE_W-1:0]     i_timeout_ticks,
    output logic [AW-1:0]                  o_rd_addr,
    output ssc_pkg::t_s1_ctl               o_ctl
);

    logic [AW-1:0]              r_pos, n_pos;
    logic                       r_pair, n_pair;
    logic [ssc_pkg::IDLE_W-1:0] r_idle, n_idle;

    logic                       pos_last;
    logic [AW-1:0]              pos_inc;
    logic [ssc_pkg::IDLE_W-1:0] idle_inc;
    logic                       tick_to;

    // position wraps after the last bank
    assign pos_last = (r_pos == AW'(BANK_COUNT - 1));
    assign pos_inc  = pos_last ? '0 : r_pos + 1'b1;

    // watchdog count, saturating
    assign idle_inc = r_pair ? '0 :
                      (r_idle == ssc_pkg::IDLE_MAX) ? r_idle : r_idle + 1'b1;
    assign tick_to  = (idle_inc >= i_timeout_ticks);

    // opcode decode
    always_comb begin
        n_pos           = r_pos;
        n_pair          = r_pair;
        n_idle          = r_idle;
        o_rd_addr       = r_pos;
        o_ctl           = '0;
        o_ctl.opcode    = i_opcode;
        unique case (i_opcode)
            ssc_pkg::OP_BYTE: begin
                n_pos      = pos_inc;
                o_ctl.wrap = pos_last;
                if (!pos_inc[0]) begin
                    n_pair = 1'b1;
                end
            end
            ssc_pkg::OP_TICK: begin
                n_pair = 1'b0;
                n_idle = idle_inc;
                if (tick_to) begin
                    n_idle          = '0;
                    n_pos           = '0;
                    o_ctl.timed_out = 1'b1;
                end
            end
            ssc_pkg::OP_READ: begin
                o_rd_addr      = i_bank_index[AW-1:0];
                o_ctl.in_range = ({1'b0, i_bank_index} <
                                  (ssc_pkg::BANK_IDX_W + 1)'(BANK_COUNT));
            end
            default: begin
            end
        endcase
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_pair <= 1'b0;
            r_idle <= '0;
        end else if (i_accept) begin
            r_pos  <= n_pos;
            r_pair <= n_pair;
            r_idle <= n_idle;
        end
    end

endmodule

FILE: hdl/sensor_scan_collector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_scan_collector
// Collects two-byte-per-decoder sensor dumps into a bank memory, runs the
// dump watchdog and answers bank reads.
// ----------------------------------------------------------------------------
// Takes one item per clock while the output is not stalled, and gives one
// result per item. The edge that accepts an item also starts the registered
// read of its bank; the old bank contents come back in the following cycle,
// and the result is written into the output register when the pipeline next
// advances. The registered read of the bank memory is followed by the
// write-back of the new byte, and a read that meets a write to the same bank
// is forwarded. Ready drops only while a result waits in the output register
// and the sink is not taking it.
// After reset every bank reads as zero; timeout_ticks resets to 10 and may be
// written through i_cfg_wr_en / i_cfg_wr_data while the block is idle.
`include "sensor_scan_collector_defines.svh"

module sensor_scan_collector #(
    parameter int DECODERS = 5
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [ssc_pkg::IDLE_W-1:0] i_cfg_wr_data,
    ssc_in_if.sink                     i_in,
    ssc_out_if.source                  o_out
);

    localparam int BANK_COUNT = 2 * DECODERS;
    localparam int AW         = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;

    logic [ssc_pkg::IDLE_W-1:0] r_timeout_ticks;

    logic                       advance;
    logic                       accept;
    logic [AW-1:0]              rd_addr;
    ssc_pkg::t_s1_ctl           n_ctl;

    logic                       r_s1_valid;
    ssc_pkg::t_s1_ctl           r_s1_ctl;
    logic [AW-1:0]              r_s1_addr;
    logic [ssc_pkg::DATA_W-1:0] r_s1_data;

    logic [ssc_pkg::DATA_W-1:0] old_bits;
    logic                       bank_changed;
    logic                       pend_acc;
    logic                       wr_en;
    logic                       r_pending, n_pending;

    ssc_pkg::t_result           n_res;
    ssc_pkg::t_result           r_res;
    logic                       r_out_valid;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ticks <= ssc_pkg::TIMEOUT_RESET;
        end else if (i_cfg_wr_en) begin
            r_timeout_ticks <= i_cfg_wr_data;
        end
    end

    // pipeline moves whenever the output register is free or being drained
    assign advance    = !r_out_valid || o_out.ready;
    assign i_in.ready = advance;
    assign accept     = i_in.valid && advance;

    ssc_front #(
        .BANK_COUNT (BANK_COUNT),
        .AW         (AW)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_opcode        (i_in.opcode),
        .i_bank_index    (i_in.bank_index),
        .i_timeout_ticks (r_timeout_ticks),
        .o_rd_addr       (rd_addr),
        .o_ctl           (n_ctl)
    );

    ssc_bank_mem #(
        .DEPTH (BANK_COUNT),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (rd_addr),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (r_s1_data),
        .o_rd_data (old_bits)
    );

    // memory stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ctl  <= n_ctl;
            r_s1_addr <= rd_addr;
            r_s1_data <= i_in.data_byte;
        end
    end

    // read-modify-write of the current bank
    assign bank_changed = (old_bits != r_s1_data);
    assign pend_acc     = r_pending || bank_changed;
    assign wr_en        = r_s1_valid && advance && (r_s1_ctl.opcode == ssc_pkg::OP_BYTE);

    // result assembly and change tracking
    always_comb begin
        n_res     = '0;
        n_pending = r_pending;
        case (r_s1_ctl.opcode)
            ssc_pkg::OP_BYTE: begin
                n_res.request_dump = r_s1_ctl.wrap;
                n_res.scan_done    = r_s1_ctl.wrap;
                n_res.scan_changed = r_s1_ctl.wrap && pend_acc;
                n_pending          = r_s1_ctl.wrap ? 1'b0 : pend_acc;
            end
            ssc_pkg::OP_TICK: begin
                n_res.request_dump = r_s1_ctl.timed_out;
                n_res.timed_out    = r_s1_ctl.timed_out;
            end
            ssc_pkg::OP_READ: begin
                n_res.bank_bits = r_s1_ctl.in_range ? old_bits : '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
        end else if (wr_en) begin
            r_pending <= n_pending;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_s1_valid) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.request_dump = r_res.request_dump;
    assign o_out.scan_done    = r_res.scan_done;
    assign o_out.scan_changed = r_res.scan_changed;
    assign o_out.timed_out    = r_res.timed_out;
    assign o_out.bank_bits    = r_res.bank_bits;

    // checks
    `SSC_ASSERT(a_changed_needs_done, !(o_out.valid && o_out.scan_changed && !o_out.scan_done))
    `SSC_ASSERT(a_done_not_timeout, !(o_out.valid && o_out.scan_done && o_out.timed_out))
    `SSC_ASSERT_NEXT(a_accept_enters_stage, accept, r_s1_valid)
    `SSC_ASSERT_NEXT(a_stage_reaches_output, r_s1_valid && advance, r_out_valid)

endmodule

FILE: tb/sensor_scan_collector_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_scan_collector_test
// Self-checking bench for the sensor scan collector. Dump bytes, watchdog
// ticks and bank reads go through the input channel with random gaps, and
// the result channel stalls at random. An in-bench mirror of the banks,
// scan position and watchdog predicts every result, and the results are
// compared field by field in order. Several watchdog limits are used, from
// zero to 255.
// ----------------------------------------------------------------------------
module sensor_scan_collector_test;

    localparam int DECODERS   = 5;
    localparam int BANK_COUNT = 2 * DECODERS;
    localparam logic [ssc_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam int MAX_REPORTS = 10;

    // clock and reset
    logic clk = 1'b0;
    logic rst_n;
    logic                       cfg_wr_en;
    logic [ssc_pkg::IDLE_W-1:0] cfg_wr_data;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    ssc_in_if  in_ch ();
    ssc_out_if out_ch ();

    sensor_scan_collector #(
        .DECODERS(DECODERS)
    ) DUT (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .i_in         (in_ch.sink),
        .o_out        (out_ch.source)
    );

    // mirror of the block state
    logic [ssc_pkg::DATA_W-1:0] bank_mirror [BANK_COUNT];
    logic [4:0]                 scan_pos;
    logic                       scan_dirty;
    logic                       pair_seen;
    logic [ssc_pkg::IDLE_W-1:0] idle_ticks;
    logic [ssc_pkg::IDLE_W-1:0] tick_limit;

    ssc_pkg::t_result pending_results [$];
    ssc_pkg::t_result got_result;
    ssc_pkg::t_result want_result;

    int  items_sent;
    int  scans_seen;
    int  restarts_seen;
    int  reads_seen;
    int  mismatch_count;
    int  stray_count;
    bit  idling_on;

    // next result of the block for one accepted item, updates the mirror
    function automatic ssc_pkg::t_result predict_item(
            input logic [ssc_pkg::OPCODE_W-1:0]   op,
            input logic [ssc_pkg::DATA_W-1:0]     data,
            input logic [ssc_pkg::BANK_IDX_W-1:0] bank);
        ssc_pkg::t_result r;
        logic [4:0]       nxt;
        r = '0;
        case (op)
            ssc_pkg::OP_BYTE: begin
                if (bank_mirror[scan_pos] != data) scan_dirty = 1'b1;
                bank_mirror[scan_pos] = data;
                nxt = (scan_pos == BANK_COUNT - 1) ? 5'd0 : scan_pos + 5'd1;
                scan_pos = nxt;
                if (nxt == 5'd0) begin
                    r.request_dump = 1'b1;
                    r.scan_done    = 1'b1;
                    r.scan_changed = scan_dirty;
                    scan_dirty     = 1'b0;
                    scans_seen++;
                end
                if (!nxt[0]) pair_seen = 1'b1;
            end
            ssc_pkg::OP_TICK: begin
                if (pair_seen) idle_ticks = '0;
                else if (idle_ticks != ssc_pkg::IDLE_MAX) idle_ticks = idle_ticks + 1'b1;
                pair_seen = 1'b0;
                if (idle_ticks >= tick_limit) begin
                    idle_ticks  = '0;
                    scan_pos    = '0;
                    r.request_dump = 1'b1;
                    r.timed_out    = 1'b1;
                    restarts_seen++;
                end
            end
            ssc_pkg::OP_READ: begin
                if (bank < BANK_COUNT) r.bank_bits = bank_mirror[bank];
                reads_seen++;
            end
            default: ;
        endcase
        return r;
    endfunction

    // dump byte for the current position: repeat, random or one bit flipped
    function automatic logic [ssc_pkg::DATA_W-1:0] next_dump_byte(input int mode);
        logic [ssc_pkg::DATA_W-1:0] cur;
        cur = bank_mirror[scan_pos];
        case (mode)
            0:       return cur;
            1:       return (ssc_pkg::DATA_W)'($urandom);
            default: return cur ^ (8'h01 << $urandom_range(0, 7));
        endcase
    endfunction

    // drive one item at the falling edge, record it once accepted
    task automatic send_item(input logic [ssc_pkg::OPCODE_W-1:0]   op,
                             input logic [ssc_pkg::DATA_W-1:0]     data,
                             input logic [ssc_pkg::BANK_IDX_W-1:0] bank);
        int gap;
        @(negedge clk);
        if (idling_on && $urandom_range(0, 7) == 0) begin
            in_ch.valid = 1'b0;
            gap = $urandom_range(1, 18);
            repeat (gap) @(negedge clk);
        end
        in_ch.valid      = 1'b1;
        in_ch.opcode     = op;
        in_ch.data_byte  = data;
        in_ch.bank_index = bank;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        pending_results.push_back(predict_item(op, data, bank));
        items_sent++;
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain;
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic write_limit(input logic [ssc_pkg::IDLE_W-1:0] limit);
        drain();
        @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = limit;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        tick_limit  = limit;
    endtask

    // reads of the cleared banks, in and out of range, the unused opcode and a tick
    task automatic test_reset_contents;
        send_item(ssc_pkg::OP_READ, 8'h00, 5'd0);
        send_item(ssc_pkg::OP_READ, 8'hFF, 5'd9);
        send_item(ssc_pkg::OP_READ, 8'h00, 5'd10);
        send_item(ssc_pkg::OP_READ, 8'hFF, 5'd31);
        send_item(OP_UNUSED, 8'hFF, 5'd31);
        send_item(ssc_pkg::OP_TICK, 8'h00, 5'd0);
    endtask

    // one full scan with extreme byte values, then read back
    task automatic test_full_scan;
        logic [ssc_pkg::DATA_W-1:0] dump [BANK_COUNT];
        dump = '{8'hFF, 8'h00, 8'h80, 8'h01, 8'hAA, 8'h55, 8'hFF, 8'h7F, 8'hFE, 8'h00};
        foreach (dump[i]) send_item(ssc_pkg::OP_BYTE, dump[i], (ssc_pkg::BANK_IDX_W)'(i));
        send_item(ssc_pkg::OP_READ, 8'h00, 5'd0);
        send_item(ssc_pkg::OP_READ, 8'h00, 5'd8);
        send_item(ssc_pkg::OP_READ, 8'h00, 5'd9);
    endtask

    // short limits: restart after one idle tick, and on every tick at zero
    task automatic test_watchdog_limits;
        write_limit(8'd1);
        send_item(ssc_pkg::OP_TICK, 8'h00, 5'd0);
        send_item(ssc_pkg::OP_TICK, 8'h00, 5'd0);
        write_limit(8'd0);
        send_item(ssc_pkg::OP_BYTE, 8'h3C, 5'd0);
        send_item(ssc_pkg::OP_TICK, 8'h00, 5'd0);
        send_item(ssc_pkg::OP_BYTE, 8'hC3, 5'd0);
        send_item(ssc_pkg::OP_READ, 8'h00, 5'd0);
    endtask

    // idle count climbs all the way to the widest limit
    task automatic test_watchdog_ceiling;
        write_limit(8'd255);
        idling_on = 1'b1;
        repeat (3) send_item(ssc_pkg::OP_BYTE, (ssc_pkg::DATA_W)'($urandom),
                             (ssc_pkg::BANK_IDX_W)'($urandom));
        repeat (260) send_item(ssc_pkg::OP_TICK, (ssc_pkg::DATA_W)'($urandom),
                               (ssc_pkg::BANK_IDX_W)'($urandom));
    endtask

    // mostly whole dumps with random content, mixed with ticks, reads and noise
    task automatic test_random_traffic(input int n_items,
                                       input logic [ssc_pkg::IDLE_W-1:0] limit,
                                       input bit idle_en);
        int sent;
        int kind;
        int mode;
        int n;
        write_limit(limit);
        idling_on = idle_en;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
                mode = $urandom_range(0, 2);
                repeat (BANK_COUNT) begin
                    send_item(ssc_pkg::OP_BYTE, next_dump_byte(mode),
                              (ssc_pkg::BANK_IDX_W)'($urandom));
                    sent++;
                end
            end else if (kind < 62) begin
                n = $urandom_range(1, 14);
                repeat (n) begin
                    send_item(ssc_pkg::OP_TICK, (ssc_pkg::DATA_W)'($urandom),
                              (ssc_pkg::BANK_IDX_W)'($urandom));
                    sent++;
                end
            end else if (kind < 78) begin
                n = $urandom_range(1, 4);
                repeat (n) begin
                    send_item(ssc_pkg::OP_READ, (ssc_pkg::DATA_W)'($urandom),
                              (ssc_pkg::BANK_IDX_W)'($urandom));
                    sent++;
                end
            end else if (kind < 90) begin
                n = $urandom_range(1, BANK_COUNT - 1);
                repeat (n) begin
                    send_item(ssc_pkg::OP_BYTE, (ssc_pkg::DATA_W)'($urandom),
                              (ssc_pkg::BANK_IDX_W)'($urandom));
                    sent++;
                end
            end else begin
                send_item((ssc_pkg::OPCODE_W)'($urandom), (ssc_pkg::DATA_W)'($urandom),
                          (ssc_pkg::BANK_IDX_W)'($urandom));
                sent++;
            end
        end
    endtask

    // result side stalls in random bursts
    initial begin
        int stall;
        out_ch.ready = 1'b1;
        stall = 0;
        forever begin
            @(negedge clk);
            if (stall > 0) begin
                out_ch.ready = 1'b0;
                stall--;
            end else if (idling_on && $urandom_range(0, 7) == 0) begin
                out_ch.ready = 1'b0;
                stall = $urandom_range(1, 18) - 1;
            end else begin
                out_ch.ready = 1'b1;
            end
        end
    end

    // compare every accepted result with the oldest prediction
    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready) begin
            got_result = '{out_ch.request_dump, out_ch.scan_done, out_ch.scan_changed,
                           out_ch.timed_out, out_ch.bank_bits};
            if (pending_results.size() == 0) begin
                stray_count++;
                $display("[%0t] result with no item outstanding: %p", $realtime, got_result);
            end else begin
                want_result = pending_results.pop_front();
                if (got_result !== want_result) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("[%0t] mismatch (expected/actual): request_dump %b/%b scan_done %b/%b",
                                 $realtime,
                                 want_result.request_dump, got_result.request_dump,
                                 want_result.scan_done, got_result.scan_done);
                        $display("    scan_changed %b/%b timed_out %b/%b bank_bits %h/%h",
                                 want_result.scan_changed, got_result.scan_changed,
                                 want_result.timed_out, got_result.timed_out,
                                 want_result.bank_bits, got_result.bank_bits);
                    end
                end
            end
        end
    end

    // run limit
    initial begin
        #50_000_000;
        $display("sensor_scan_collector_test failed");
        $finish;
    end

    initial begin
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        in_ch.valid      = 1'b0;
        in_ch.opcode     = '0;
        in_ch.data_byte  = '0;
        in_ch.bank_index = '0;
        foreach (bank_mirror[i]) bank_mirror[i] = '0;
        scan_pos       = '0;
        scan_dirty     = 1'b0;
        pair_seen      = 1'b0;
        idle_ticks     = '0;
        tick_limit     = ssc_pkg::TIMEOUT_RESET;
        items_sent     = 0;
        scans_seen     = 0;
        restarts_seen  = 0;
        reads_seen     = 0;
        mismatch_count = 0;
        stray_count    = 0;
        idling_on      = 1'b0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_contents();
        test_full_scan();
        test_watchdog_limits();
        test_watchdog_ceiling();
        test_random_traffic(250, 8'd10, 1'b1);
        test_random_traffic(250, 8'd1, 1'b1);
        test_random_traffic(250, (ssc_pkg::IDLE_W)'($urandom_range(2, 254)), 1'b1);
        test_random_traffic(200, 8'd0, 1'b1);
        test_random_traffic(150, 8'd255, 1'b0);
        test_random_traffic(200, 8'd6, 1'b0);

        drain();
        repeat (10) @(posedge clk);
        $display("Ran %0d items: %0d completed scans, %0d watchdog restarts, %0d bank reads,",
                 items_sent, scans_seen, restarts_seen, reads_seen);
        $display("over watchdog limits 0, 1, 6, 10, 255 and one random; %0d mismatches.",
                 mismatch_count);
        if (mismatch_count == 0 && stray_count == 0 && pending_results.size() == 0) begin
            $display("sensor_scan_collector_test passed");
        end else begin
            $display("sensor_scan_collector_test failed");
        end
        $finish;
    end

endmodule
